// ----- src/bs3_pkg.sv -----
// shared types, widths and divider constants for the 3x3 box smoothing filter
`default_nettype none

package bs3_pkg;

  localparam int MAX_DIM_DEFAULT = 1024;
  localparam int SIZE_RESET      = 512;
  localparam int CFG_W           = 11;
  localparam int CHAN_W          = 16;
  localparam int POS_W           = 10;
  localparam int NUM_CH          = 3;
  localparam int WIN_DIM         = 3;

  // channel slots inside a pixel
  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;

  // sum of one column of three pixels and of the whole window
  localparam int COL_W = CHAN_W + 2;
  localparam int SUM_W = CHAN_W + 4;

  // division by 1, 3 or 9 as a multiply by a scaled reciprocal, exact below 2**SUM_W
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int PROD_W      = SUM_W + RECIP_W;

  localparam logic [RECIP_W-1:0] RECIP_ONE   = RECIP_W'(1) << RECIP_SHIFT;
  localparam logic [RECIP_W-1:0] RECIP_THIRD = RECIP_W'(5592406);
  localparam logic [RECIP_W-1:0] RECIP_NINTH = RECIP_W'(1864136);

  // power of three in the neighbor count
  localparam logic [1:0] DIV3_NONE  = 2'd0;
  localparam logic [1:0] DIV3_ONCE  = 2'd1;
  localparam logic [1:0] DIV3_TWICE = 2'd2;

  typedef logic [CHAN_W-1:0] chan_t;
  typedef chan_t [NUM_CH-1:0] pix_t;
  typedef pix_t [WIN_DIM-1:0] win_col_t;
  // window cell [a][b] holds the pixel a-2 rows and b-2 columns from the newest one
  typedef win_col_t [WIN_DIM-1:0] win_t;

  // one result request from the window stage to the averaging pipeline
  typedef struct packed {
    logic [WIN_DIM-1:0] row_en;
    logic [WIN_DIM-1:0] col_en;
    logic [POS_W-1:0]   row;
    logic [POS_W-1:0]   col;
    logic               eof;
  } iss_t;

  function automatic logic [RECIP_W-1:0] div_recip(input logic [1:0] k3);
    logic [RECIP_W-1:0] m;
    case (k3)
      DIV3_NONE:  m = RECIP_ONE;
      DIV3_ONCE:  m = RECIP_THIRD;
      DIV3_TWICE: m = RECIP_NINTH;
      default:    m = RECIP_ONE;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

// ----- src/bs3_ram.sv -----
// generic simple dual port ram with registered read, old data on read during write
`default_nettype none

module bs3_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ----- src/bs3_front.sv -----
// raster position, line buffers, 3x3 window and result request sequencing
`default_nettype none

module bs3_front #(
  parameter int MAX_DIM = bs3_pkg::MAX_DIM_DEFAULT
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       restart,
  input  wire logic [$clog2(MAX_DIM)-1:0] last_idx,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire bs3_pkg::pix_t              in_pix,
  output logic                            iss_valid,
  input  wire logic                       iss_ready,
  output bs3_pkg::iss_t                   iss,
  output bs3_pkg::win_t                   win
);

  import bs3_pkg::*;

  localparam int PW = $clog2(MAX_DIM);

  // result kinds of one pixel, in emission order
  localparam logic [1:0] RES_UP_LEFT = 2'd0;
  localparam logic [1:0] RES_LEFT    = 2'd1;
  localparam logic [1:0] RES_UP      = 2'd2;
  localparam logic [1:0] RES_HERE    = 2'd3;

  typedef struct packed {
    logic r_ge1;
    logic r_ge2;
    logic c_ge1;
    logic c_ge2;
  } bnd_t;

  logic          accept;
  logic [PW-1:0] row_r, row_nxt, col_r, col_nxt;

  logic          s1_valid_r, s1_valid_nxt;
  pix_t          s1_pix_r;
  logic [PW-1:0] s1_row_r, s1_col_r;
  bnd_t          s1_bnd_r, bnd_now;
  logic [3:0]    s1_pend_r, pend_now;

  pix_t          above_rd, two_rd;

  logic [3:0]    pend_r, pend_nxt;
  win_t          win_r;
  logic [PW-1:0] job_row_r, job_col_r;
  bnd_t          job_bnd_r;

  logic [1:0]    kind;
  logic          row_lag, col_lag;
  logic          iss_fire, single, s2_take, s1_move;

  assign accept = in_valid && !in_stall;

  // position of the next pixel
  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (restart) begin
      row_nxt = '0;
      col_nxt = '0;
    end else if (accept) begin
      if (col_r == last_idx) begin
        col_nxt = '0;
        row_nxt = (row_r == last_idx) ? '0 : row_r + PW'(1);
      end else begin
        col_nxt = col_r + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  always_comb begin
    bnd_now.r_ge1 = (row_r != '0);
    bnd_now.r_ge2 = (row_r > PW'(1));
    bnd_now.c_ge1 = (col_r != '0);
    bnd_now.c_ge2 = (col_r > PW'(1));
    pend_now[RES_UP_LEFT] = bnd_now.c_ge1 && bnd_now.r_ge1;
    pend_now[RES_LEFT]    = bnd_now.c_ge1 && (row_r == last_idx);
    pend_now[RES_UP]      = (col_r == last_idx) && bnd_now.r_ge1;
    pend_now[RES_HERE]    = (col_r == last_idx) && (row_r == last_idx);
  end

  // line buffers, read at the incoming column
  bs3_ram #(
    .WIDTH ($bits(pix_t)),
    .DEPTH (MAX_DIM)
  ) u_line_above (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (col_r),
    .wr_data (in_pix),
    .rd_en   (accept),
    .rd_addr (col_r),
    .rd_data (above_rd)
  );

  bs3_ram #(
    .WIDTH ($bits(pix_t)),
    .DEPTH (MAX_DIM)
  ) u_line_two_above (
    .clk     (clk),
    .wr_en   (s1_move),
    .wr_addr (s1_col_r),
    .wr_data (above_rd),
    .rd_en   (accept),
    .rd_addr (col_r),
    .rd_data (two_rd)
  );

  // input stage
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_r  <= in_pix;
      s1_row_r  <= row_r;
      s1_col_r  <= col_r;
      s1_bnd_r  <= bnd_now;
      s1_pend_r <= pend_now;
    end
  end

  // pick the oldest outstanding result
  always_comb begin
    if (pend_r[RES_UP_LEFT]) begin
      kind = RES_UP_LEFT;
    end else if (pend_r[RES_LEFT]) begin
      kind = RES_LEFT;
    end else if (pend_r[RES_UP]) begin
      kind = RES_UP;
    end else begin
      kind = RES_HERE;
    end
    row_lag = (kind == RES_UP_LEFT) || (kind == RES_UP);
    col_lag = (kind == RES_UP_LEFT) || (kind == RES_LEFT);
  end

  always_comb begin
    iss.row_en = {1'b1, job_bnd_r.r_ge1, row_lag && job_bnd_r.r_ge2};
    iss.col_en = {1'b1, job_bnd_r.c_ge1, col_lag && job_bnd_r.c_ge2};
    iss.row    = POS_W'(job_row_r - PW'(row_lag));
    iss.col    = POS_W'(job_col_r - PW'(col_lag));
    iss.eof    = (kind == RES_HERE);
  end

  assign iss_valid = (pend_r != '0);
  assign iss_fire  = iss_valid && iss_ready;
  assign single    = ((pend_r & (pend_r - 4'd1)) == 4'd0);
  assign s2_take   = single && (iss_ready || (pend_r == '0));
  assign s1_move   = s1_valid_r && s2_take;
  assign in_stall  = s1_valid_r && !s2_take;

  always_comb begin
    pend_nxt = pend_r;
    if (iss_fire) begin
      pend_nxt[kind] = 1'b0;
    end
    if (s1_move) begin
      pend_nxt = s1_pend_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  // window slides one column per pixel
  always_ff @(posedge clk) begin
    if (s1_move) begin
      for (int a = 0; a < WIN_DIM; a++) begin
        win_r[a][0] <= win_r[a][1];
        win_r[a][1] <= win_r[a][2];
      end
      win_r[0][2] <= two_rd;
      win_r[1][2] <= above_rd;
      win_r[2][2] <= s1_pix_r;
      job_row_r   <= s1_row_r;
      job_col_r   <= s1_col_r;
      job_bnd_r   <= s1_bnd_r;
    end
  end

  assign win = win_r;

  a_eof_retires: assert property (@(posedge clk) disable iff (!rst_n)
    iss_fire && iss.eof |-> s2_take)
    else $error("bottom-right result issued with later results pending");

  a_pend_only_drops: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_move |=> (pend_r & ~$past(pend_r)) == 4'd0)
    else $error("result request appeared without a new pixel");

  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s2_take |=> s1_valid_r && $stable(s1_col_r) && $stable(s1_pend_r))
    else $error("input stage changed while held");

endmodule

`default_nettype wire

// ----- src/bs3_mean.sv -----
// neighbor sums and division by the neighbor count, with the result register
`default_nettype none

module bs3_mean (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        iss_valid,
  output logic                             iss_ready,
  input  wire bs3_pkg::iss_t               iss,
  input  wire bs3_pkg::win_t               win,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output bs3_pkg::pix_t                    out_pix,
  output logic [bs3_pkg::POS_W-1:0]        out_row,
  output logic [bs3_pkg::POS_W-1:0]        out_col,
  output logic                             out_eof
);

  import bs3_pkg::*;

  typedef struct packed {
    logic [1:0]       shift;
    logic [1:0]       k3;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             eof;
  } meta_t;

  typedef logic [WIN_DIM-1:0][COL_W-1:0] colsums_t;

  logic va_r, vb_r, vc_r;
  logic rdy_b, rdy_c;

  logic [1:0] nr, nc;
  meta_t      meta_now, meta_a_r, meta_b_r;

  colsums_t [NUM_CH-1:0]             colsum_nxt, colsum_a_r;
  logic [WIN_DIM-1:0]                col_en_a_r;
  logic [NUM_CH-1:0][SUM_W-1:0]      total_nxt, total_b_r;

  logic [RECIP_W-1:0]                recip;
  logic [NUM_CH-1:0][PROD_W-1:0]     prod;
  pix_t                              q_pix_r;
  logic [POS_W-1:0]                  q_row_r, q_col_r;
  logic                              q_eof_r;

  assign rdy_c     = !vc_r || !out_stall;
  assign rdy_b     = !vb_r || rdy_c;
  assign iss_ready = !va_r || rdy_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      if (iss_ready) begin
        va_r <= iss_valid;
      end
      if (rdy_b) begin
        vb_r <= va_r;
      end
      if (rdy_c) begin
        vc_r <= vb_r;
      end
    end
  end

  // count = rows x cols, split into a power of two and a power of three
  always_comb begin
    nr = 2'd1 + 2'(iss.row_en[1]) + 2'(iss.row_en[0]);
    nc = 2'd1 + 2'(iss.col_en[1]) + 2'(iss.col_en[0]);
    meta_now.shift = 2'(nr == 2'd2) + 2'(nc == 2'd2);
    meta_now.k3    = 2'(nr == 2'd3) + 2'(nc == 2'd3);
    meta_now.row   = iss.row;
    meta_now.col   = iss.col;
    meta_now.eof   = iss.eof;
  end

  // column sums over the rows inside the image
  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      for (int b = 0; b < WIN_DIM; b++) begin
        colsum_nxt[ch][b] = (iss.row_en[0] ? COL_W'(win[0][b][ch]) : '0)
                          + (iss.row_en[1] ? COL_W'(win[1][b][ch]) : '0)
                          + (iss.row_en[2] ? COL_W'(win[2][b][ch]) : '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (iss_valid && iss_ready) begin
      colsum_a_r <= colsum_nxt;
      col_en_a_r <= iss.col_en;
      meta_a_r   <= meta_now;
    end
  end

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      total_nxt[ch] = (col_en_a_r[0] ? SUM_W'(colsum_a_r[ch][0]) : '0)
                    + (col_en_a_r[1] ? SUM_W'(colsum_a_r[ch][1]) : '0)
                    + (col_en_a_r[2] ? SUM_W'(colsum_a_r[ch][2]) : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (va_r && rdy_b) begin
      total_b_r <= total_nxt;
      meta_b_r  <= meta_a_r;
    end
  end

  // truncating divide: shift out the power of two, multiply by the reciprocal of 1, 3 or 9
  assign recip = div_recip(meta_b_r.k3);

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      prod[ch] = PROD_W'(total_b_r[ch] >> meta_b_r.shift) * PROD_W'(recip);
    end
  end

  always_ff @(posedge clk) begin
    if (vb_r && rdy_c) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        q_pix_r[ch] <= prod[ch][RECIP_SHIFT +: CHAN_W];
      end
      q_row_r <= meta_b_r.row;
      q_col_r <= meta_b_r.col;
      q_eof_r <= meta_b_r.eof;
    end
  end

  assign out_valid = vc_r;
  assign out_pix   = q_pix_r;
  assign out_row   = q_row_r;
  assign out_col   = q_col_r;
  assign out_eof   = q_eof_r;

  a_sum_holds: assert property (@(posedge clk) disable iff (!rst_n)
    vb_r && !rdy_c |=> vb_r && $stable(total_b_r) && $stable(meta_b_r))
    else $error("window sum changed while the result register was full");

endmodule

`default_nettype wire

// ----- src/box_smooth_3x3_rgb.sv -----
// top level of the streaming 3x3 box smoothing filter for square rgb images
`default_nettype none

// Streaming 3x3 mean filter over a square RGB image fed in raster order, 16 bits
// per channel. Each result is the truncating mean of the pixel and those of its
// eight neighbors that lie inside the image (9 inside, 6 on an edge, 4 at a
// corner, fewer for images one or two pixels wide), tagged with its row and
// column. Results trail the input by one row and one column: the last pixel of
// every row after the first brings out two results, every pixel of the last row
// but its first (which brings none) brings out two, the bottom-right pixel brings
// out four, and out_end_of_frame marks the result for the bottom-right pixel.
// Rate: the result path issues one result per cycle while out_stall is low, so
// the input takes one pixel per cycle, and a pixel with more than one result
// holds the input until only its last result is left to issue; out_stall holds
// it as well. The result path is a five register pipeline: input register
// with the line buffer read, window, column sums, window sum, then the quotient
// in the output register. Writing cfg_image_size (0 acts as 1, values above
// MAX_DIM act as MAX_DIM) restarts the frame at row 0, column 0; write it only
// with the pipeline drained. The line buffers are MAX_DIM deep and are not
// cleared: stale contents are masked out by position, so no clearing pass runs.

module box_smooth_3x3_rgb #(
  parameter int MAX_DIM = bs3_pkg::MAX_DIM_DEFAULT
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // pixel requests
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [bs3_pkg::CHAN_W-1:0]  in_red,
  input  wire logic [bs3_pkg::CHAN_W-1:0]  in_green,
  input  wire logic [bs3_pkg::CHAN_W-1:0]  in_blue,
  // smoothed pixel requests
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [bs3_pkg::CHAN_W-1:0]       out_red,
  output logic [bs3_pkg::CHAN_W-1:0]       out_green,
  output logic [bs3_pkg::CHAN_W-1:0]       out_blue,
  output logic [bs3_pkg::POS_W-1:0]        out_row,
  output logic [bs3_pkg::POS_W-1:0]        out_col,
  output logic                             out_end_of_frame,
  // image size register
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [bs3_pkg::CFG_W-1:0]   cfg_image_size
);

  import bs3_pkg::*;

  localparam int PW       = $clog2(MAX_DIM);
  localparam int RST_SIZE = (SIZE_RESET > MAX_DIM) ? MAX_DIM : SIZE_RESET;

  logic          cfg_fire;
  logic [PW-1:0] last_r, last_nxt;

  pix_t          in_pix, out_pix;
  logic          iss_valid, iss_ready;
  iss_t          iss;
  win_t          win;

  // register is always writable, the write restarts the frame
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  // keep the last row/column index, with the size clamped to 1..MAX_DIM
  always_comb begin
    last_nxt = last_r;
    if (cfg_fire) begin
      if (cfg_image_size == '0) begin
        last_nxt = '0;
      end else if (int'(cfg_image_size) > MAX_DIM) begin
        last_nxt = PW'(MAX_DIM - 1);
      end else begin
        last_nxt = PW'(cfg_image_size - CFG_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= PW'(RST_SIZE - 1);
    end else begin
      last_r <= last_nxt;
    end
  end

  always_comb begin
    in_pix[CH_RED]   = in_red;
    in_pix[CH_GREEN] = in_green;
    in_pix[CH_BLUE]  = in_blue;
  end

  // line buffers, window and per-pixel result sequencing
  bs3_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .restart   (cfg_fire),
    .last_idx  (last_r),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_pix    (in_pix),
    .iss_valid (iss_valid),
    .iss_ready (iss_ready),
    .iss       (iss),
    .win       (win)
  );

  // masked sums, divide by count, output register
  bs3_mean u_mean (
    .clk       (clk),
    .rst_n     (rst_n),
    .iss_valid (iss_valid),
    .iss_ready (iss_ready),
    .iss       (iss),
    .win       (win),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_pix   (out_pix),
    .out_row   (out_row),
    .out_col   (out_col),
    .out_eof   (out_end_of_frame)
  );

  assign out_red   = out_pix[CH_RED];
  assign out_green = out_pix[CH_GREEN];
  assign out_blue  = out_pix[CH_BLUE];

endmodule

`default_nettype wire

// ----- dv/tb_box_smooth_3x3_rgb.sv -----
// self-checking testbench for the streaming 3x3 rgb box smoothing filter
`default_nettype none

module tb_box_smooth_3x3_rgb;
  timeunit 1ns;
  timeprecision 1ps;

  import bs3_pkg::*;

  localparam int MAX_DIM      = MAX_DIM_DEFAULT;
  localparam int IDLE_PCT     = 38;   // chance in a hundred that a side idles in a cycle
  localparam int DRAIN_CYCLES = 12;   // five stage result pipeline plus margin
  localparam int RAND_PIXELS  = 280;
  localparam int PEEK_PIXELS  = 8;    // too few to finish any result at a large size
  localparam int QUIET_SIZE   = 10;   // frame size of the stretch with no idling

  // one smoothed pixel request as the result port shows it
  typedef struct packed {
    chan_t            red;
    chan_t            green;
    chan_t            blue;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             eof;
  } smoothed_t;

  logic             clk;
  logic             rst_n          = 1'b0;
  logic             in_valid       = 1'b0;
  logic             in_stall;
  chan_t            in_red         = '0;
  chan_t            in_green       = '0;
  chan_t            in_blue        = '0;
  logic             out_valid;
  logic             out_stall      = 1'b0;
  chan_t            out_red;
  chan_t            out_green;
  chan_t            out_blue;
  logic [POS_W-1:0] out_row;
  logic [POS_W-1:0] out_col;
  logic             out_end_of_frame;
  logic             cfg_valid      = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_image_size = '0;

  box_smooth_3x3_rgb #(
    .MAX_DIM(MAX_DIM)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_red           (in_red),
    .in_green         (in_green),
    .in_blue          (in_blue),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_row          (out_row),
    .out_col          (out_col),
    .out_end_of_frame (out_end_of_frame),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_image_size   (cfg_image_size)
  );

  // ---------------------------------------------------------------------------
  // filter predictor: its own line buffers, window, raster position and size
  // ---------------------------------------------------------------------------
  pix_t             line_prev  [MAX_DIM];  // row just above the newest pixel
  pix_t             line_prev2 [MAX_DIM];  // row two above
  pix_t             win [3][3];            // [a][b] holds pixel (r-2+a, c-2+b)
  int               next_row;
  int               next_col;
  logic [CFG_W-1:0] size_reg = CFG_W'(SIZE_RESET);

  smoothed_t        smooth_q[$];           // smoothed pixels still owed by the block

  int pixels_sent;
  int results_seen;
  int failures;
  int sizes_written;
  bit no_idle;                             // quiet stretch: neither side idles

  // size register as the block uses it: 0 acts as 1, oversize clamps to MAX_DIM
  function automatic int dim_now();
    if (size_reg == '0) return 1;
    if (int'(size_reg) > MAX_DIM) return MAX_DIM;
    return int'(size_reg);
  endfunction

  // mean over the in-image neighbors of (rr,cc) as the window stands at input (r,c)
  function automatic void emit_mean(int rr, int cc, int r, int c, int n);
    int        sums [NUM_CH];
    int        cnt;
    int        pr;
    int        pc;
    smoothed_t res;
    for (int ch = 0; ch < NUM_CH; ch++) sums[ch] = 0;
    cnt = 0;
    for (int a = 0; a < 3; a++) begin
      pr = r - 2 + a;
      // rows outside the image or outside the 3x3 around rr stay out of the sum
      if (pr >= 0 && pr < n && pr >= rr - 1 && pr <= rr + 1) begin
        for (int b = 0; b < 3; b++) begin
          pc = c - 2 + b;
          if (pc >= 0 && pc < n && pc >= cc - 1 && pc <= cc + 1) begin
            for (int ch = 0; ch < NUM_CH; ch++) sums[ch] += int'(win[a][b][ch]);
            cnt++;
          end
        end
      end
    end
    if (cnt == 0) cnt = 1;
    res.red   = chan_t'(sums[CH_RED] / cnt);
    res.green = chan_t'(sums[CH_GREEN] / cnt);
    res.blue  = chan_t'(sums[CH_BLUE] / cnt);
    res.row   = POS_W'(rr);
    res.col   = POS_W'(cc);
    res.eof   = (rr == n - 1) && (cc == n - 1);
    smooth_q.push_back(res);
  endfunction

  // advance the predictor by one accepted pixel and queue what it completes
  function automatic void predict_pixel(pix_t p);
    int n;
    int r;
    int c;
    n = dim_now();
    // a size change can leave the position past the new edge
    if (next_row >= n || next_col >= n) begin
      next_row = 0;
      next_col = 0;
    end
    r = next_row;
    c = next_col;
    for (int a = 0; a < 3; a++) begin
      win[a][0] = win[a][1];
      win[a][1] = win[a][2];
    end
    win[0][2]     = line_prev2[c];
    win[1][2]     = line_prev[c];
    win[2][2]     = p;
    line_prev2[c] = line_prev[c];
    line_prev[c]  = p;
    // one row and one column late; the last row also reports itself
    if (c >= 1) begin
      if (r >= 1) emit_mean(r - 1, c - 1, r, c, n);
      if (r == n - 1) emit_mean(r, c - 1, r, c, n);
    end
    // the right edge column has no later pixel to wait for
    if (c == n - 1) begin
      if (r >= 1) emit_mean(r - 1, c, r, c, n);
      if (r == n - 1) emit_mean(r, c, r, c, n);
    end
    c++;
    if (c >= n) begin
      c = 0;
      r++;
      if (r >= n) r = 0;
    end
    next_row = r;
    next_col = c;
  endfunction

  // ---------------------------------------------------------------------------
  // clock, reset and time limit
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // far beyond the slowest legal run of a few hundred pixels
  initial begin
    #20_000_000;
    $display("%0t ns: run timed out with %0d smoothed pixels outstanding",
             $time, smooth_q.size());
    $display("Verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // result side: random stall, and every accepted request checked in order
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_stall <= (rst_n && !no_idle) ? ($urandom_range(99) < IDLE_PCT) : 1'b0;
  end

  function automatic void check_field(string name, smoothed_t want, int exp_v, int got_v);
    if (exp_v != got_v) begin
      failures++;
      $display("%0t ns: %s wrong at pixel (%0d,%0d): expected %0d, actual %0d",
               $time, name, want.row, want.col, exp_v, got_v);
    end
  endfunction

  always @(posedge clk) begin : check_results
    smoothed_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (smooth_q.size() == 0) begin
        failures++;
        $display("%0t ns: unexpected result: expected none, actual pixel (%0d,%0d)",
                 $time, out_row, out_col);
      end else begin
        want = smooth_q.pop_front();
        check_field("out_red", want, want.red, out_red);
        check_field("out_green", want, want.green, out_green);
        check_field("out_blue", want, want.blue, out_blue);
        check_field("out_row", want, want.row, out_row);
        check_field("out_col", want, want.col, out_col);
        check_field("out_end_of_frame", want, want.eof, out_end_of_frame);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // pixel and size register drivers
  // ---------------------------------------------------------------------------
  function automatic pix_t make_pix(chan_t r, chan_t g, chan_t b);
    pix_t p;
    p[CH_RED]   = r;
    p[CH_GREEN] = g;
    p[CH_BLUE]  = b;
    return p;
  endfunction

  // channel values lean on the extremes so full-scale sums show up often
  function automatic chan_t rand_chan();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return chan_t'($urandom);
    endcase
  endfunction

  function automatic pix_t rand_pix();
    return make_pix(rand_chan(), rand_chan(), rand_chan());
  endfunction

  // valid is dropped for a random number of cycles, never chosen from stall
  task automatic idle_gap();
    if (!no_idle) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
  endtask

  // returns at the edge that took the request, valid still high
  task automatic send_pixel(pix_t p);
    idle_gap();
    in_valid <= 1'b1;
    in_red   <= p[CH_RED];
    in_green <= p[CH_GREEN];
    in_blue  <= p[CH_BLUE];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_pixel(p);
    pixels_sent++;
  endtask

  // always waits on the clock before checking, so valid is never lowered and raised in one step
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (smooth_q.size() != 0);
  endtask

  // a size write restarts the frame; only done with the pipeline empty
  task automatic write_size(logic [CFG_W-1:0] value);
    hold_until_drained();
    // pixels that complete no result may still be in flight
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid      <= 1'b1;
    cfg_image_size <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    size_reg  = value;
    next_row  = 0;
    next_col  = 0;
    sizes_written++;
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // size out of reset is 512: the first few pixels finish nothing yet
  task automatic test_reset_size();
    repeat (PEEK_PIXELS) send_pixel(rand_pix());
  endtask

  // one pixel images: size 0 acts as 1, each pixel is its own mean and ends a frame
  task automatic test_single_pixel();
    write_size('0);
    send_pixel(make_pix('1, '0, 16'hA5A5));
    send_pixel(make_pix('0, '1, 16'h5A5A));
    send_pixel(make_pix(16'h8001, 16'h7FFE, '1));
    write_size(CFG_W'(1));
    send_pixel(make_pix('1, '1, '1));
    send_pixel(make_pix('0, '0, '0));
  endtask

  // two by two: every pixel is a corner, four results burst from the last pixel
  task automatic test_two_by_two();
    write_size(CFG_W'(2));
    send_pixel(make_pix('1, '1, '1));
    send_pixel(make_pix('1, '1, '0));
    send_pixel(make_pix('1, '0, 16'h0003));
    send_pixel(make_pix('1, '1, 16'h0001));
  endtask

  // three by three: corners over 4, edges over 6, the center over all 9
  task automatic test_three_by_three();
    write_size(CFG_W'(3));
    for (int i = 0; i < 9; i++) begin
      send_pixel(make_pix((i % 2 == 1) ? chan_t'('1) : chan_t'('0),
                          chan_t'(i * 7281), rand_chan()));
    end
  endtask

  // widest image: the start of the first row finishes nothing
  task automatic test_max_width();
    write_size(CFG_W'(MAX_DIM));
    repeat (PEEK_PIXELS) send_pixel(rand_pix());
  endtask

  // all-ones size clamps to MAX_DIM: again nothing early
  task automatic test_oversize_clamp();
    write_size('1);
    repeat (PEEK_PIXELS) send_pixel(rand_pix());
  endtask

  // random small sizes, one or two whole frames then a partial one cut by the next write
  task automatic test_random_frames();
    int sent;
    int phase;
    int sz;
    int count;
    sent  = 0;
    phase = 0;
    while (sent < RAND_PIXELS) begin
      // phase 0 is a long run with no idling on either side
      sz      = (phase == 0) ? QUIET_SIZE : $urandom_range(1, 12);
      no_idle = (phase == 0);
      write_size((sz == 1 && $urandom_range(1) == 1) ? CFG_W'(0) : CFG_W'(sz));
      count = sz * sz * $urandom_range(1, 2) + $urandom_range(0, sz);
      if (count > RAND_PIXELS - sent) count = RAND_PIXELS - sent;
      for (int i = 0; i < count; i++) begin
        // sender holds off until the block has delivered everything owed
        if ((phase == 0 && i == count / 2) || $urandom_range(39) == 0) begin
          hold_until_drained();
        end
        send_pixel(rand_pix());
      end
      sent += count;
      phase++;
    end
    no_idle = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    pixels_sent   = 0;
    results_seen  = 0;
    failures      = 0;
    sizes_written = 0;
    no_idle       = 1'b0;
    next_row      = 0;
    next_col      = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_size();
    test_single_pixel();
    test_two_by_two();
    test_three_by_three();
    test_max_width();
    test_oversize_clamp();
    test_random_frames();

    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d pixels and %0d smoothed results over %0d size writes",
             pixels_sent, results_seen, sizes_written);
    $display("whole frames one to twelve pixels square with mid-frame restarts;");
    $display("reset, full width and clamped sizes checked for no early results");
    if (failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
